@@ rtl/core/bf_pkg.sv @@
// bf_pkg: shared types and constants for the shortest-path block.
// Used by bf_relax and bellman_ford_shortest_paths; no dependencies.
`default_nettype none
package bf_pkg;

  localparam int VC_W     = 7;
  localparam int VERTEX_W = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;
  localparam int CFG_W    = 32;
  localparam int PADDR_W  = 3;

  localparam logic signed [DIST_W-1:0] UNREACHED = 32'sd999;

  // register index, taken from paddr[2]
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_SOURCE       = 1'b1;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic [VERTEX_W-1:0]        edge_from;
    logic [VERTEX_W-1:0]        edge_to;
    logic signed [WEIGHT_W-1:0] edge_weight;
  } in_beat_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]      vertex;
    logic signed [DIST_W-1:0] distance;
    logic                     edges_dropped;
    logic                     last;
  } out_beat_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]        from_v;
    logic [VERTEX_W-1:0]        to_v;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  localparam int EDGE_W = $bits(edge_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_E,
    ST_RD_A,
    ST_RD_B,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/bf_ram.sv @@
// bf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/core/bf_relax.sv @@
// bf_relax: shared add/compare unit for one edge relaxation.
// Depends on bf_pkg.
`default_nettype none
module bf_relax (
  input  wire logic signed [bf_pkg::DIST_W-1:0]   dist_a,
  input  wire logic signed [bf_pkg::WEIGHT_W-1:0] weight,
  input  wire logic signed [bf_pkg::DIST_W-1:0]   dist_b,
  output      logic signed [bf_pkg::DIST_W-1:0]   cand,
  output      logic                               take
);

  logic signed [bf_pkg::DIST_W-1:0] w_ext;

  assign w_ext = bf_pkg::DIST_W'(weight);
  assign cand  = dist_a + w_ext;
  assign take  = (dist_a != bf_pkg::UNREACHED) && (cand < dist_b);

endmodule
`default_nettype wire

@@ rtl/core/bellman_ford_shortest_paths.sv @@
// bellman_ford_shortest_paths: top level, sequencer, edge and distance stores.
// Depends on bf_pkg, bf_ram, bf_relax. Edge beats are taken back to back.
// Run beat: presets the distances, then over n-1 passes steps each stored edge
// through RD_E, RD_A, RD_B, CMP, or only RD_E, RD_A if an endpoint is outside
// (one distance RAM read port); then EMIT_RD, EMIT_LD per emitted vertex.
// No input is taken during a run. Reset clears control state, not the stores.
`default_nettype none
module bellman_ford_shortest_paths #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire bf_pkg::in_beat_t           in_data,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      bf_pkg::out_beat_t          out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bf_pkg::CFG_W-1:0]   pwdata,
  output      logic [bf_pkg::CFG_W-1:0]   prdata,
  output      logic                       pready
);

  localparam int DAW = $clog2(MAX_VERTICES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int VCW = bf_pkg::VC_W;

  // configuration
  logic [VCW-1:0]             vc_r;
  logic [bf_pkg::VERTEX_W-1:0] src_r;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bf_pkg::REG_SOURCE) ?
                  bf_pkg::CFG_W'(src_r) : bf_pkg::CFG_W'(vc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= VCW'(64);
      src_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == bf_pkg::REG_SOURCE) begin
        src_r <= pwdata[bf_pkg::VERTEX_W-1:0];
      end else begin
        vc_r <= pwdata[VCW-1:0];
      end
    end
  end

  // control state
  bf_pkg::state_t state_r, state_nxt;
  logic [ECW-1:0] ec_r, ec_nxt;
  logic           drop_r, drop_nxt;
  logic [VCW-1:0] n_r, n_nxt;
  logic [VCW-1:0] pass_r, pass_nxt;
  logic [EAW-1:0] k_r, k_nxt;
  logic [DAW-1:0] v_r, v_nxt;
  logic signed [bf_pkg::DIST_W-1:0] da_r, da_nxt;
  logic              out_valid_r, out_valid_nxt;
  bf_pkg::out_beat_t out_beat_r, out_beat_nxt;

  // RAM ports
  logic                      e_we, e_re;
  logic [EAW-1:0]            e_waddr, e_raddr;
  logic [bf_pkg::EDGE_W-1:0] e_wdata, e_rdata;
  bf_pkg::edge_t             edge_q, edge_in;
  logic                      d_we, d_re;
  logic [DAW-1:0]            d_waddr, d_raddr;
  logic [bf_pkg::DIST_W-1:0] d_wdata, d_rdata;
  logic signed [bf_pkg::DIST_W-1:0] dist_q;

  logic signed [bf_pkg::DIST_W-1:0] cand;
  logic take;

  logic in_acc, out_free, out_load;
  logic last_v, last_k, last_pass, edge_ok, empty_run, is_src;
  logic [VCW-1:0] n_eff;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != bf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign edge_q  = bf_pkg::edge_t'(e_rdata);
  assign dist_q  = d_rdata;
  assign edge_in = '{from_v: in_data.edge_from, to_v: in_data.edge_to,
                     weight: in_data.edge_weight};

  assign n_eff = (vc_r == '0) ? VCW'(1) :
                 (vc_r > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vc_r;

  assign last_v    = (VCW'(v_r) + VCW'(1)) == n_r;
  assign last_k    = (ECW'(k_r) + ECW'(1)) == ec_r;
  assign last_pass = pass_r == (n_r - VCW'(1));
  assign empty_run = (n_r == VCW'(1)) || (ec_r == '0);
  assign is_src    = VCW'(v_r) == VCW'(src_r);
  assign edge_ok   = (VCW'(edge_q.from_v) < n_r) && (VCW'(edge_q.to_v) < n_r);

  bf_ram #(.WIDTH(bf_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bf_ram #(.WIDTH(bf_pkg::DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  bf_relax u_relax (
    .dist_a (da_r),
    .weight (edge_q.weight),
    .dist_b (dist_q),
    .cand   (cand),
    .take   (take)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bf_pkg::ST_IDLE: begin
        if (in_acc && in_data.kind == bf_pkg::KIND_RUN) state_nxt = bf_pkg::ST_INIT;
      end
      bf_pkg::ST_INIT: begin
        if (last_v) state_nxt = empty_run ? bf_pkg::ST_EMIT_RD : bf_pkg::ST_RD_E;
      end
      bf_pkg::ST_RD_E: state_nxt = bf_pkg::ST_RD_A;
      bf_pkg::ST_RD_A: begin
        if (edge_ok) begin
          state_nxt = bf_pkg::ST_RD_B;
        end else begin
          state_nxt = (last_k && last_pass) ? bf_pkg::ST_EMIT_RD : bf_pkg::ST_RD_E;
        end
      end
      bf_pkg::ST_RD_B: state_nxt = bf_pkg::ST_CMP;
      bf_pkg::ST_CMP: begin
        state_nxt = (last_k && last_pass) ? bf_pkg::ST_EMIT_RD : bf_pkg::ST_RD_E;
      end
      bf_pkg::ST_EMIT_RD: state_nxt = bf_pkg::ST_EMIT_LD;
      bf_pkg::ST_EMIT_LD: begin
        if (out_free) state_nxt = last_v ? bf_pkg::ST_IDLE : bf_pkg::ST_EMIT_RD;
      end
      default: state_nxt = bf_pkg::ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ec_nxt       = ec_r;
    drop_nxt     = drop_r;
    n_nxt        = n_r;
    pass_nxt     = pass_r;
    k_nxt        = k_r;
    v_nxt        = v_r;
    da_nxt       = da_r;
    out_load     = 1'b0;
    out_beat_nxt = out_beat_r;
    e_we         = 1'b0;
    e_waddr      = ec_r[EAW-1:0];
    e_wdata      = edge_in;
    e_re         = 1'b0;
    e_raddr      = k_r;
    d_we         = 1'b0;
    d_waddr      = v_r;
    d_wdata      = is_src ? '0 : bf_pkg::UNREACHED;
    d_re         = 1'b0;
    d_raddr      = v_r;
    unique case (state_r)
      bf_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == bf_pkg::KIND_RUN) begin
            n_nxt = n_eff;
            v_nxt = '0;
          end else if (ec_r < ECW'(MAX_EDGES)) begin
            e_we   = 1'b1;
            ec_nxt = ec_r + ECW'(1);
          end else begin
            drop_nxt = 1'b1;
          end
        end
      end
      bf_pkg::ST_INIT: begin
        d_we     = 1'b1;
        v_nxt    = last_v ? '0 : v_r + DAW'(1);
        pass_nxt = VCW'(1);
        k_nxt    = '0;
      end
      bf_pkg::ST_RD_E: begin
        e_re = 1'b1;
      end
      bf_pkg::ST_RD_A: begin
        d_re    = edge_ok;
        d_raddr = edge_q.from_v[DAW-1:0];
      end
      bf_pkg::ST_RD_B: begin
        da_nxt  = dist_q;
        d_re    = 1'b1;
        d_raddr = edge_q.to_v[DAW-1:0];
      end
      bf_pkg::ST_CMP: begin
        d_we    = take;
        d_waddr = edge_q.to_v[DAW-1:0];
        d_wdata = cand;
      end
      bf_pkg::ST_EMIT_RD: begin
        d_re = 1'b1;
      end
      bf_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_beat_nxt = '{vertex: bf_pkg::VERTEX_W'(v_r), distance: dist_q,
                           edges_dropped: drop_r, last: last_v};
          v_nxt        = v_r + DAW'(1);
          if (last_v) begin
            ec_nxt   = '0;
            drop_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // advance to the next edge, or the next pass
    if ((state_r == bf_pkg::ST_CMP) || (state_r == bf_pkg::ST_RD_A && !edge_ok)) begin
      if (last_k) begin
        k_nxt    = '0;
        pass_nxt = pass_r + VCW'(1);
      end else begin
        k_nxt = k_r + EAW'(1);
      end
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bf_pkg::ST_IDLE;
      ec_r        <= '0;
      drop_r      <= 1'b0;
      n_r         <= VCW'(1);
      pass_r      <= VCW'(1);
      k_r         <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ec_r        <= ec_nxt;
      drop_r      <= drop_nxt;
      n_r         <= n_nxt;
      pass_r      <= pass_nxt;
      k_r         <= k_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r       <= da_nxt;
    out_beat_r <= out_beat_nxt;
  end

  a_dist_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    d_we |-> (state_r == bf_pkg::ST_INIT || state_r == bf_pkg::ST_CMP))
    else $error("distance write outside preset or relax");

  a_edge_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= ECW'(MAX_EDGES))
    else $error("edge count beyond capacity");

  a_run_clears_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_beat_nxt.last) |=> (state_r == bf_pkg::ST_IDLE && ec_r == '0 && !drop_r))
    else $error("run end did not clear edge list");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

@@ test/tb_bellman_ford_shortest_paths.sv @@
// tb_bellman_ford_shortest_paths: self-checking bench for the shortest-path block.
// Streams edge and run beats, predicts every run's distances, checks each output beat.
// Depends on bf_pkg and bellman_ford_shortest_paths.
`timescale 1ns / 1ps
module tb_bellman_ford_shortest_paths;

  localparam int MAX_V     = 64;
  localparam int MAX_E     = 256;
  localparam int SETTLE    = 8;
  localparam int LONG_HOLD = 600;
  localparam int MAX_SHOWN = 10;

  logic                       clk      = 1'b0;
  logic                       rst_n    = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  bf_pkg::in_beat_t           in_data  = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  bf_pkg::out_beat_t          out_data;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [bf_pkg::PADDR_W-1:0] paddr    = '0;
  logic [bf_pkg::CFG_W-1:0]   pwdata   = '0;
  logic [bf_pkg::CFG_W-1:0]   prdata;
  logic                       pready;

  bellman_ford_shortest_paths #(
    .MAX_VERTICES(MAX_V),
    .MAX_EDGES   (MAX_E)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the block's edge list and registers
  bf_pkg::edge_t               arc_list[MAX_E];
  int                          arc_total = 0;
  bit                          arcs_lost = 1'b0;
  logic [bf_pkg::VC_W-1:0]     vc_reg    = 7'd64;
  logic [bf_pkg::VERTEX_W-1:0] src_reg   = '0;
  bf_pkg::out_beat_t           dist_expected[$];
  int                          mismatches = 0;
  bit                          tx_steady = 1'b0;
  bit                          rx_steady = 1'b0;
  bit                          hold_go   = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_vc(int vc);
    if (vc < 1) return 1;
    if (vc > MAX_V) return MAX_V;
    return vc;
  endfunction

  function automatic int pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 60);
    if (r < 70) return -int'($urandom_range(1, 8));
    if (r < 80) return r[0] ? 32767 : -32768;
    return int'($signed(16'($urandom)));
  endfunction

  function automatic bf_pkg::in_beat_t mk_arc(int src_v, int dst_v, int w);
    bf_pkg::in_beat_t r;
    r.kind        = bf_pkg::KIND_EDGE;
    r.edge_from   = bf_pkg::VERTEX_W'(src_v);
    r.edge_to     = bf_pkg::VERTEX_W'(dst_v);
    r.edge_weight = bf_pkg::WEIGHT_W'(w);
    return r;
  endfunction

  function automatic bf_pkg::in_beat_t run_cmd();
    bf_pkg::in_beat_t r;
    r.kind        = bf_pkg::KIND_RUN;
    r.edge_from   = bf_pkg::VERTEX_W'($urandom);
    r.edge_to     = bf_pkg::VERTEX_W'($urandom);
    r.edge_weight = bf_pkg::WEIGHT_W'($urandom);
    return r;
  endfunction

  function automatic bf_pkg::in_beat_t rand_arc(int n);
    int lim;
    lim = ($urandom_range(0, 9) == 0) ? MAX_V - 1 : n - 1;
    return mk_arc($urandom_range(0, lim), $urandom_range(0, lim), pick_weight());
  endfunction

  function automatic bf_pkg::in_beat_t noise_beat();
    bf_pkg::in_beat_t r;
    r      = run_cmd();
    r.kind = 1'($urandom);
    return r;
  endfunction

  // relax all stored arcs n-1 times, queue one distance per vertex
  task automatic solve_run();
    longint            sp_dist[MAX_V];
    longint            cand;
    int                n;
    int                a;
    int                b;
    bf_pkg::out_beat_t r;
    n = clamp_vc(int'(vc_reg));
    for (int v = 0; v < n; v++) sp_dist[v] = bf_pkg::UNREACHED;
    if (src_reg < n) sp_dist[src_reg] = 0;
    for (int p = 1; p < n; p++) begin
      for (int k = 0; k < arc_total; k++) begin
        a = arc_list[k].from_v;
        b = arc_list[k].to_v;
        if (a < n && b < n && sp_dist[a] != bf_pkg::UNREACHED) begin
          cand = sp_dist[a] + longint'($signed(arc_list[k].weight));
          if (cand < sp_dist[b]) sp_dist[b] = cand;
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vertex        = bf_pkg::VERTEX_W'(v);
      r.distance      = sp_dist[v][bf_pkg::DIST_W-1:0];
      r.edges_dropped = arcs_lost;
      r.last          = (v == n - 1);
      dist_expected   = {dist_expected, r};
    end
    arc_total = 0;
    arcs_lost = 1'b0;
  endtask

  task automatic note_beat(bf_pkg::in_beat_t b);
    if (b.kind == bf_pkg::KIND_EDGE) begin
      if (arc_total < MAX_E) begin
        arc_list[arc_total] = '{b.edge_from, b.edge_to, b.edge_weight};
        arc_total++;
      end else begin
        arcs_lost = 1'b1;
      end
    end else begin
      solve_run();
    end
  endtask

  task automatic send_beat(bf_pkg::in_beat_t b);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_beat(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (dist_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic reg_sel, int value);
    logic [bf_pkg::CFG_W-1:0] word;
    word = $urandom;
    if (reg_sel == bf_pkg::REG_VERTEX_COUNT) word[bf_pkg::VC_W-1:0] = bf_pkg::VC_W'(value);
    else word[bf_pkg::VERTEX_W-1:0] = bf_pkg::VERTEX_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == bf_pkg::REG_VERTEX_COUNT) vc_reg = word[bf_pkg::VC_W-1:0];
    else src_reg = word[bf_pkg::VERTEX_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_graph(int vc, int src);
    write_reg(bf_pkg::REG_VERTEX_COUNT, vc);
    write_reg(bf_pkg::REG_SOURCE, src);
  endtask

  task automatic test_reset_state();
    send_beat(run_cmd());
    drain();
  endtask

  task automatic test_small_graph();
    set_graph(5, 0);
    send_beat(mk_arc(0, 1, 4));
    send_beat(mk_arc(0, 2, 1));
    send_beat(mk_arc(2, 1, -2));
    send_beat(mk_arc(1, 3, 32767));
    send_beat(mk_arc(3, 4, -32768));
    send_beat(mk_arc(5, 0, -100));
    send_beat(mk_arc(63, 63, -1));
    send_beat(run_cmd());
    drain();
    // negative cycle keeps shrinking every pass
    set_graph(3, 1);
    send_beat(mk_arc(1, 2, -1));
    send_beat(mk_arc(2, 1, -1));
    send_beat(run_cmd());
    drain();
  endtask

  task automatic test_unreached_mark();
    set_graph(4, 3);
    send_beat(mk_arc(3, 0, 999));
    send_beat(mk_arc(0, 1, 1));
    send_beat(mk_arc(3, 2, 1000));
    send_beat(run_cmd());
    drain();
    set_graph(4, 10);
    send_beat(mk_arc(0, 1, 1));
    send_beat(run_cmd());
    drain();
  endtask

  task automatic test_vertex_limits();
    set_graph(0, 0);
    send_beat(mk_arc(0, 0, -7));
    send_beat(run_cmd());
    drain();
    set_graph(127, 63);
    send_beat(mk_arc(63, 0, -5));
    send_beat(mk_arc(0, 62, 32767));
    send_beat(run_cmd());
    drain();
  endtask

  task automatic test_edge_overflow();
    int n;
    int total;
    n     = $urandom_range(2, 6);
    total = MAX_E + $urandom_range(0, 8);
    set_graph(n, $urandom_range(0, n - 1));
    for (int i = 0; i < total; i++) send_beat(rand_arc(n));
    send_beat(run_cmd());
    send_beat(run_cmd());
    drain();
  endtask

  task automatic test_backpressure();
    set_graph(16, 0);
    tx_steady = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(rand_arc(16));
    send_beat(run_cmd());
    hold_go = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(rand_arc(16));
    send_beat(run_cmd());
    for (int i = 0; i < 3; i++) send_beat(rand_arc(16));
    send_beat(run_cmd());
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_random_graphs(int items);
    int sent;
    int r;
    int vc;
    int n;
    int phase_end;
    int grp;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 19);
      if (r < 11) vc = $urandom_range(2, 12);
      else if (r == 11) vc = 1;
      else if (r < 14) vc = 64;
      else if (r == 14) vc = 0;
      else if (r < 17) vc = $urandom_range(65, 127);
      else vc = $urandom_range(13, 63);
      n = clamp_vc(vc);
      set_graph(vc, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                : $urandom_range(0, n - 1));
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      phase_end = sent + $urandom_range(12, 30);
      while (sent < phase_end) begin
        grp = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
        for (int i = 0; i < grp; i++) begin
          send_beat(($urandom_range(0, 9) == 0) ? noise_beat() : rand_arc(n));
          sent++;
        end
        send_beat(run_cmd());
        sent++;
      end
      drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin : rx_stall_gen
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        left = 0;
      end else if (rx_steady) begin
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    bf_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dist_expected.size() == 0) begin
        if (mismatches < MAX_SHOWN)
          $display("unexpected beat: vertex %0d distance %0d", out_data.vertex,
                   out_data.distance);
        mismatches++;
      end else begin
        want = dist_expected.pop_front();
        if (out_data.vertex !== want.vertex || out_data.distance !== want.distance ||
            out_data.edges_dropped !== want.edges_dropped || out_data.last !== want.last) begin
          if (mismatches < MAX_SHOWN)
            $display({"mismatch exp/got: vertex %0d/%0d distance %0d/%0d",
                      " dropped %0b/%0b last %0b/%0b"},
                     want.vertex, out_data.vertex, want.distance, out_data.distance,
                     want.edges_dropped, out_data.edges_dropped, want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_small_graph();
    test_unreached_mark();
    test_vertex_limits();
    test_edge_overflow();
    test_backpressure();
    test_random_graphs(120);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
